@@ design/box_blur_3x3_edge_aware_unit_assert.svh @@
// assertion macros used by the box blur queue module
// no dependencies; included by bbe_queue.sv, which carries concurrent assertions
`ifndef BOX_BLUR_3X3_EDGE_AWARE_UNIT_ASSERT_SVH
`define BOX_BLUR_3X3_EDGE_AWARE_UNIT_ASSERT_SVH

// same-cycle implication
`define BBE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BBE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/bbe_pkg.sv @@
// shared types, constants and helper functions of the 3x3 box blur
// no dependencies; used by all box blur modules
package bbe_pkg;

   localparam int PIX_W        = 24;
   localparam int CH_W         = 8;
   localparam int SUM_W        = 12;
   localparam int REC_SHIFT    = 20;
   localparam int REC_W        = 21;
   localparam int PROD_W       = SUM_W + REC_W;
   localparam int ROW_W        = 13;
   localparam int CFG_WIDTH_W  = 11;
   localparam int CFG_HEIGHT_W = 13;
   localparam int HEIGHT_LIMIT = 4096;
   localparam int Q_DEPTH      = 4;
   localparam int Q_AW         = 2;
   localparam int Q_CW         = 3;

   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_DRAIN = 1'b1;

   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   typedef struct packed {
      logic emit;
      logic load_row;
      logic top_ok;
      logic bot_ok;
      logic left_ok;
      logic right_ok;
      logic frame_end;
   } bbe_ctrl_type;

   typedef struct packed {
      bbe_ctrl_type       ctrl;
      logic [PIX_W-1:0]   bot;
      logic [PIX_W-1:0]   mid;
      logic [PIX_W-1:0]   top;
   } bbe_entry_type;

   // ceil(2^REC_SHIFT / n), exact for every window sum
   function automatic logic [REC_W-1:0] recip(input logic [3:0] n);
      logic [REC_W-1:0] k;
      unique case (n)
         4'd1:    k = REC_W'(1048576);
         4'd2:    k = REC_W'(524288);
         4'd3:    k = REC_W'(349526);
         4'd4:    k = REC_W'(262144);
         4'd6:    k = REC_W'(174763);
         4'd9:    k = REC_W'(116509);
         default: k = '0;
      endcase
      return k;
   endfunction

endpackage

@@ design/box_blur_3x3_edge_aware_unit.sv @@
// 3x3 edge-aware box blur top level: register port, front end, queue, back end
// depends on bbe_pkg, bbe_front, bbe_queue, bbe_back
//
// Takes RGB pixels in raster order, one per clock when ready; returns each as the
// rounded-half-up mean of its in-bounds 3x3 neighbours (1, 2, 3, 4, 6 or 9 of them).
// Results follow the stream by frame_width+1 transactions; after the last pixel of a
// frame send frame_width+1 drain transactions (tuser high) to flush the tail, the
// last result carrying tlast. Sustained rate is one transaction per clock while the
// queue has room, set by the single write and single read port of each of the four
// row banks; rsp_tvalid rises once the releasing transaction has passed the fetch
// register, a four-entry queue and a sum, multiply and output pipeline. Row banks
// are not cleared after reset. Write frame_width and frame_height only between frames.
module box_blur_3x3_edge_aware_unit #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,    // red_in, green_in, blue_in
   input  logic        req_tuser,    // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,    // red_out, green_out, blue_out
   output logic        rsp_tlast,    // frame_end
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int CW = $clog2(MAX_WIDTH);

   logic [bbe_pkg::CFG_WIDTH_W-1:0]  width_ff;
   logic [bbe_pkg::CFG_HEIGHT_W-1:0] height_ff;
   logic                             csr_wr;
   logic [CW:0]                      eff_width;
   logic [bbe_pkg::ROW_W-1:0]        eff_height;

   bbe_pkg::bbe_entry_type           push_entry, head_entry;
   logic                             q_push, q_pop, q_not_empty;
   logic [bbe_pkg::Q_CW-1:0]         q_count;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= bbe_pkg::CFG_WIDTH_W'(1024);
         height_ff <= bbe_pkg::CFG_HEIGHT_W'(768);
      end else if (csr_wr) begin
         if (csr_paddr[2] == bbe_pkg::CSR_FRAME_WIDTH) begin
            width_ff <= csr_pwdata[bbe_pkg::CFG_WIDTH_W-1:0];
         end else begin
            height_ff <= csr_pwdata[bbe_pkg::CFG_HEIGHT_W-1:0];
         end
      end
   end

   always_comb begin
      if (csr_paddr[2] == bbe_pkg::CSR_FRAME_HEIGHT) begin
         csr_prdata = 32'(height_ff);
      end else begin
         csr_prdata = 32'(width_ff);
      end
   end

   // zero counts as one, oversize saturates
   always_comb begin
      priority if (width_ff == '0) begin
         eff_width = (CW+1)'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         eff_width = (CW+1)'(MAX_WIDTH);
      end else begin
         eff_width = (CW+1)'(width_ff);
      end
      priority if (height_ff == '0) begin
         eff_height = bbe_pkg::ROW_W'(1);
      end else if (32'(height_ff) > 32'(bbe_pkg::HEIGHT_LIMIT)) begin
         eff_height = bbe_pkg::ROW_W'(bbe_pkg::HEIGHT_LIMIT);
      end else begin
         eff_height = height_ff;
      end
   end

   bbe_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .eff_width  (eff_width),
      .eff_height (eff_height),
      .q_count    (q_count),
      .q_push     (q_push),
      .q_entry    (push_entry)
   );

   bbe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head_entry (head_entry),
      .not_empty  (q_not_empty),
      .count      (q_count)
   );

   bbe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_entry    (head_entry),
      .q_valid    (q_not_empty),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ design/bbe_queue.sv @@
// short queue of classified items between front and back end
// depends on bbe_pkg and box_blur_3x3_edge_aware_unit_assert.svh
`include "box_blur_3x3_edge_aware_unit_assert.svh"

module bbe_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  bbe_pkg::bbe_entry_type push_entry,
   input  logic                   pop,
   output bbe_pkg::bbe_entry_type head_entry,
   output logic                   not_empty,
   output logic [bbe_pkg::Q_CW-1:0] count
);

   bbe_pkg::bbe_entry_type entries_ff [bbe_pkg::Q_DEPTH];
   logic [bbe_pkg::Q_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [bbe_pkg::Q_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [bbe_pkg::Q_CW-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + bbe_pkg::Q_CW'(push) - bbe_pkg::Q_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_entry = entries_ff[rd_ptr_ff];
   assign not_empty  = (count_ff != '0);
   assign count      = count_ff;

   `BBE_ASSERT_IMP(a_no_overflow, clock, reset, push, count_ff < bbe_pkg::Q_CW'(bbe_pkg::Q_DEPTH), "push into full queue")
   `BBE_ASSERT_IMP(a_no_underflow, clock, reset, pop, count_ff != '0, "pop from empty queue")
   `BBE_ASSERT_NXT(a_count_up, clock, reset, push && !pop, count_ff == $past(count_ff) + bbe_pkg::Q_CW'(1), "queue count lost a push")

endmodule

@@ design/bbe_front.sv @@
// front end: stream counters, row banks and column fetch for the box blur
// depends on bbe_pkg
module bbe_front #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [23:0]                   req_tdata,   // red_in, green_in, blue_in
   input  logic                          req_tuser,   // req_type
   input  logic [$clog2(MAX_WIDTH):0]    eff_width,
   input  logic [bbe_pkg::ROW_W-1:0]     eff_height,
   input  logic [bbe_pkg::Q_CW-1:0]      q_count,
   output logic                          q_push,
   output bbe_pkg::bbe_entry_type        q_entry
);

   localparam int CW = $clog2(MAX_WIDTH);

   logic [CW-1:0]               in_col_ff, in_col_in;
   logic [bbe_pkg::ROW_W-1:0]   in_row_ff, in_row_in;
   logic [CW-1:0]               out_col_ff, out_col_in;
   logic [bbe_pkg::ROW_W-1:0]   out_row_ff, out_row_in;
   logic [CW:0]                 lag_ff, lag_in;

   logic [bbe_pkg::PIX_W-1:0]   rd_data [4];

   logic                        f1_valid_ff;
   bbe_pkg::bbe_ctrl_type       f1_ctrl_ff, f1_ctrl_in;
   logic [1:0]                  f1_slot_ff, f1_slot_in;

   logic                        accept, drain, pending, act, wr_en;
   logic                        emit, last_lag, load_row, frame_end, push_in;
   logic                        right_ok, left_ok, top_ok, bot_ok;
   logic [CW:0]                 col_inc, ocol_inc;
   logic [bbe_pkg::ROW_W-1:0]   orow_inc;
   logic [CW-1:0]               rd_col;
   logic [1:0]                  wr_slot;

   assign req_tready = (q_count + bbe_pkg::Q_CW'(f1_valid_ff))
                       < bbe_pkg::Q_CW'(bbe_pkg::Q_DEPTH);

   always_comb begin
      accept  = req_tvalid && req_tready;
      drain   = (req_tuser == bbe_pkg::REQ_DRAIN);
      pending = in_row_ff < eff_height;
      act     = accept && (drain != pending);
      wr_en   = act && !drain;
      wr_slot = in_row_ff[1:0];

      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      lag_in     = lag_ff;

      col_inc = {1'b0, in_col_ff} + 1'b1;
      if (wr_en) begin
         if (col_inc >= eff_width) begin
            in_col_in = '0;
            in_row_in = in_row_ff + 1'b1;
         end else begin
            in_col_in = col_inc[CW-1:0];
         end
      end

      ocol_inc  = {1'b0, out_col_ff} + 1'b1;
      orow_inc  = out_row_ff + 1'b1;
      right_ok  = ocol_inc < eff_width;
      left_ok   = (out_col_ff != '0);
      top_ok    = (out_row_ff != '0);
      bot_ok    = orow_inc < eff_height;
      emit      = 1'b0;
      last_lag  = 1'b0;
      frame_end = 1'b0;

      if (act) begin
         if (lag_ff <= eff_width) begin
            lag_in   = lag_ff + 1'b1;
            last_lag = (lag_ff == eff_width);
         end else begin
            emit = 1'b1;
            if (right_ok) begin
               out_col_in = ocol_inc[CW-1:0];
            end else begin
               out_col_in = '0;
               out_row_in = orow_inc;
               frame_end  = (orow_inc >= eff_height);
            end
            if (frame_end) begin
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
               lag_in     = '0;
            end
         end
      end

      // fetch the column right of the output, or column 0 of the next output row
      if (emit && right_ok) begin
         rd_col     = ocol_inc[CW-1:0];
         f1_slot_in = out_row_ff[1:0];
      end else begin
         rd_col     = '0;
         f1_slot_in = emit ? orow_inc[1:0] : 2'd0;
      end
      load_row = last_lag || (emit && !right_ok && !frame_end);
      push_in  = emit || load_row;

      f1_ctrl_in.emit      = emit;
      f1_ctrl_in.load_row  = load_row;
      f1_ctrl_in.top_ok    = top_ok;
      f1_ctrl_in.bot_ok    = bot_ok;
      f1_ctrl_in.left_ok   = left_ok;
      f1_ctrl_in.right_ok  = right_ok;
      f1_ctrl_in.frame_end = frame_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         lag_ff      <= '0;
         f1_valid_ff <= 1'b0;
      end else begin
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         lag_ff      <= lag_in;
         f1_valid_ff <= push_in;
      end
   end

   always_ff @(posedge clock) begin
      f1_ctrl_ff <= f1_ctrl_in;
      f1_slot_ff <= f1_slot_in;
   end

   // four row banks: each one write and one registered read at the fetch column
   for (genvar s = 0; s < 4; s++) begin : g_bank
      logic [bbe_pkg::PIX_W-1:0] bank_ff [MAX_WIDTH];
      logic [bbe_pkg::PIX_W-1:0] rd_ff;
      logic                      hit;

      assign hit = wr_en && (wr_slot == 2'(s));

      always_ff @(posedge clock) begin
         if (hit) begin
            bank_ff[in_col_ff] <= req_tdata;
         end
         if (hit && (in_col_ff == rd_col)) begin
            rd_ff <= req_tdata;
         end else begin
            rd_ff <= bank_ff[rd_col];
         end
      end

      assign rd_data[s] = rd_ff;
   end

   always_comb begin
      q_push         = f1_valid_ff;
      q_entry.ctrl   = f1_ctrl_ff;
      q_entry.top    = rd_data[f1_slot_ff - 2'd1];
      q_entry.mid    = rd_data[f1_slot_ff];
      q_entry.bot    = rd_data[f1_slot_ff + 2'd1];
   end

endmodule

@@ design/bbe_back.sv @@
// back end: 3x3 window, masked sums, rounding divide and output register
// depends on bbe_pkg
module bbe_back (
   input  logic                   clock,
   input  logic                   reset,
   input  bbe_pkg::bbe_entry_type q_entry,
   input  logic                   q_valid,
   output logic                   q_pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [23:0]            rsp_tdata,   // red_out, green_out, blue_out
   output logic                   rsp_tlast    // frame_end
);

   typedef logic [2:0][bbe_pkg::PIX_W-1:0] bbe_col_type;

   bbe_col_type                     win_ff [3];
   bbe_col_type                     win_in [3];
   bbe_col_type                     fetched;

   logic                            b1_valid_ff, b1_last_ff;
   logic [bbe_pkg::SUM_W-1:0]       b1_x_ff [3];
   logic [bbe_pkg::SUM_W-1:0]       b1_x_in [3];
   logic [bbe_pkg::REC_W-1:0]       b1_k_ff, b1_k_in;
   logic                            b2_valid_ff, b2_last_ff;
   logic [bbe_pkg::PROD_W-1:0]      b2_prod_ff [3];
   logic                            rsp_valid_ff, rsp_last_ff;
   logic [23:0]                     rsp_data_ff, rsp_data_in;

   logic                            en, pop, emit;
   logic [2:0]                      row_ok, col_ok;
   logic [1:0]                      rc, cc;
   logic [3:0]                      n;
   logic [bbe_pkg::SUM_W-1:0]       sum;

   assign en    = !rsp_valid_ff || rsp_tready;
   assign pop   = en && q_valid;
   assign q_pop = pop;
   assign emit  = pop && q_entry.ctrl.emit;

   always_comb begin
      fetched = {q_entry.bot, q_entry.mid, q_entry.top};
      row_ok  = {q_entry.ctrl.bot_ok, 1'b1, q_entry.ctrl.top_ok};
      col_ok  = {q_entry.ctrl.right_ok, 1'b1, q_entry.ctrl.left_ok};
      rc      = 2'd1 + 2'(q_entry.ctrl.top_ok) + 2'(q_entry.ctrl.bot_ok);
      cc      = 2'd1 + 2'(q_entry.ctrl.left_ok) + 2'(q_entry.ctrl.right_ok);
      n       = 4'(rc) * 4'(cc);
      b1_k_in = bbe_pkg::recip(n);

      // an emitting entry shifts the window by one column; otherwise it stays (a load_row entry still loads column 2)
      if (q_entry.ctrl.emit) begin
         win_in[0] = win_ff[1];
         win_in[1] = win_ff[2];
         win_in[2] = fetched;
      end else begin
         win_in = win_ff;
      end

      for (int ch = 0; ch < 3; ch++) begin
         sum = '0;
         for (int j = 0; j < 3; j++) begin
            for (int r = 0; r < 3; r++) begin
               if (row_ok[r] && col_ok[j]) begin
                  sum = sum + bbe_pkg::SUM_W'(win_in[j][r][ch*bbe_pkg::CH_W +: bbe_pkg::CH_W]);
               end
            end
         end
         b1_x_in[ch] = sum + bbe_pkg::SUM_W'(n >> 1);
      end

      for (int ch = 0; ch < 3; ch++) begin
         rsp_data_in[ch*bbe_pkg::CH_W +: bbe_pkg::CH_W] =
            b2_prod_ff[ch][bbe_pkg::REC_SHIFT +: bbe_pkg::CH_W];
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         win_ff[0] <= win_in[0];
         win_ff[1] <= win_in[1];
         win_ff[2] <= q_entry.ctrl.load_row ? fetched : win_in[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         b1_valid_ff  <= emit;
         b2_valid_ff  <= b1_valid_ff;
         rsp_valid_ff <= b2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b1_x_ff     <= b1_x_in;
         b1_k_ff     <= b1_k_in;
         b1_last_ff  <= q_entry.ctrl.frame_end;
         for (int ch = 0; ch < 3; ch++) begin
            b2_prod_ff[ch] <= bbe_pkg::PROD_W'(b1_x_ff[ch]) * bbe_pkg::PROD_W'(b1_k_ff);
         end
         b2_last_ff  <= b1_last_ff;
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= b2_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ verif/box_blur_3x3_edge_aware_unit_chk.sv @@
// checker for the 3x3 box blur: watches the request, result and register ports
// depends on bbe_pkg; predicts every result and compares it field by field
`timescale 1ns / 1ps

module box_blur_3x3_edge_aware_unit_chk #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,    // red_in, green_in, blue_in
   input  logic        req_tuser,    // req_type
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,    // red_out, green_out, blue_out
   input  logic        rsp_tlast,    // frame_end
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          mismatch_count,
   output int          blur_pending
);

   localparam logic [2:0] ADDR_WIDTH  = 3'(bbe_pkg::CSR_FRAME_WIDTH) << 2;
   localparam logic [2:0] ADDR_HEIGHT = 3'(bbe_pkg::CSR_FRAME_HEIGHT) << 2;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last;
   } blur_pixel_type;

   blur_pixel_type blurred_q[$];
   logic [23:0] row_bank[4][MAX_WIDTH];
   logic [bbe_pkg::CFG_WIDTH_W-1:0]  width_reg;
   logic [bbe_pkg::CFG_HEIGHT_W-1:0] height_reg;
   int in_col, in_row, out_col, out_row, lag;

   function automatic int eff_w();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return int'(width_reg);
   endfunction

   function automatic int eff_h();
      if (height_reg == 0) return 1;
      if (height_reg > bbe_pkg::HEIGHT_LIMIT) return bbe_pkg::HEIGHT_LIMIT;
      return int'(height_reg);
   endfunction

   function automatic void blur_next(int w, int h);
      int sr, sg, sb, n, r0, r1, c0, c1;
      logic [23:0] p;
      blur_pixel_type e;
      sr = 0; sg = 0; sb = 0; n = 0;
      r0 = (out_row > 0) ? out_row - 1 : out_row;
      r1 = (out_row + 1 < h) ? out_row + 1 : out_row;
      c0 = (out_col > 0) ? out_col - 1 : out_col;
      c1 = (out_col + 1 < w) ? out_col + 1 : out_col;
      for (int r = r0; r <= r1; r++)
         for (int c = c0; c <= c1; c++) begin
            p = (c < MAX_WIDTH) ? row_bank[r % 4][c] : '0;
            sr += p[7:0];
            sg += p[15:8];
            sb += p[23:16];
            n++;
         end
      e.red   = 8'((sr + n / 2) / n);
      e.green = 8'((sg + n / 2) / n);
      e.blue  = 8'((sb + n / 2) / n);
      out_col++;
      if (out_col >= w) begin
         out_col = 0;
         out_row++;
      end
      e.last = (out_row >= h);
      if (e.last) begin
         in_col = 0; in_row = 0; out_col = 0; out_row = 0; lag = 0;
      end
      blurred_q.push_back(e);
   endfunction

   function automatic void take_request(logic kind, logic [23:0] pix);
      int w, h;
      logic pixels_left;
      w = eff_w();
      h = eff_h();
      pixels_left = (in_row < h);
      // drains only count once the frame's pixels are in, pixels only before
      if ((kind == bbe_pkg::REQ_DRAIN) == pixels_left) return;
      if (kind == bbe_pkg::REQ_PIXEL) begin
         if (in_col < MAX_WIDTH) row_bank[in_row % 4][in_col] = pix;
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            in_row++;
         end
      end
      if (lag <= w) begin
         lag++;
         return;
      end
      blur_next(w, h);
   endfunction

   always @(posedge clock) begin
      blur_pixel_type got, want;
      if (reset) begin
         blurred_q.delete();
         width_reg  <= 11'd1024;
         height_reg <= 13'd768;
         in_col = 0; in_row = 0; out_col = 0; out_row = 0; lag = 0;
         mismatch_count <= 0;
         for (int s = 0; s < 4; s++)
            for (int c = 0; c < MAX_WIDTH; c++) row_bank[s][c] = '0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.red   = rsp_tdata[7:0];
            got.green = rsp_tdata[15:8];
            got.blue  = rsp_tdata[23:16];
            got.last  = rsp_tlast;
            if (blurred_q.size() == 0) begin
               if (mismatch_count < 10)
                  $display("%0t: unexpected result transaction r=%0d g=%0d b=%0d last=%0b",
                           $realtime, got.red, got.green, got.blue, got.last);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = blurred_q.pop_front();
               if (got !== want) begin
                  if (mismatch_count < 10)
                     $display("%0t: result mismatch exp r=%0d g=%0d b=%0d last=%0b, act r=%0d g=%0d b=%0d last=%0b",
                              $realtime, want.red, want.green, want.blue, want.last,
                              got.red, got.green, got.blue, got.last);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready) take_request(req_tuser, req_tdata);
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr == ADDR_WIDTH)  width_reg  <= csr_pwdata[bbe_pkg::CFG_WIDTH_W-1:0];
            if (csr_paddr == ADDR_HEIGHT) height_reg <= csr_pwdata[bbe_pkg::CFG_HEIGHT_W-1:0];
         end
      end
      blur_pending = blurred_q.size();
   end

endmodule

@@ verif/box_blur_3x3_edge_aware_unit_tb.sv @@
// testbench top for the 3x3 box blur: clock, reset, stimulus and verdict
// depends on bbe_pkg, box_blur_3x3_edge_aware_unit and its checker
`timescale 1ns / 1ps

module box_blur_3x3_edge_aware_unit_tb;

   localparam logic [2:0] ADDR_WIDTH  = 3'(bbe_pkg::CSR_FRAME_WIDTH) << 2;
   localparam logic [2:0] ADDR_HEIGHT = 3'(bbe_pkg::CSR_FRAME_HEIGHT) << 2;

   localparam int PAT_RANDOM  = 0;
   localparam int PAT_WHITE   = 1;
   localparam int PAT_CHECKER = 2;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0, req_tready;
   logic [23:0] req_tdata = '0;
   logic        req_tuser = bbe_pkg::REQ_PIXEL;
   logic        rsp_tvalid, rsp_tready = 1'b0, rsp_tlast;
   logic [23:0] rsp_tdata;
   logic        csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0, csr_pready;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0, csr_prdata;
   int          mismatch_count, blur_pending;
   int          items_sent = 0;
   int          rsp_stall = 0;
   logic        req_busy_mode = 1'b1, rsp_busy_mode = 1'b1;
   int          cur_w = 1024, cur_h = 768;

   box_blur_3x3_edge_aware_unit u_dut (.*);

   box_blur_3x3_edge_aware_unit_chk u_chk (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // result side back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_tvalid && rsp_tready) begin
         rsp_stall = rsp_busy_mode ? $urandom_range(0, 11) : 0;
         rsp_tready <= (rsp_stall == 0);
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_tready <= (rsp_stall == 0);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_item(logic kind, logic [23:0] data);
      int gap;
      gap = req_busy_mode ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      req_tvalid  <= 1'b0;
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // block must be idle: every result in, then the pipeline latency
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (blur_pending != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic set_frame(logic [10:0] w_raw, logic [12:0] h_raw);
      wait_idle();
      csr_write(ADDR_WIDTH, ($urandom & ~32'h7FF) | 32'(w_raw));
      csr_write(ADDR_HEIGHT, ($urandom & ~32'h1FFF) | 32'(h_raw));
      cur_w = (w_raw == 0) ? 1 : (w_raw > 1024) ? 1024 : int'(w_raw);
      cur_h = (h_raw == 0) ? 1 :
              (h_raw > bbe_pkg::HEIGHT_LIMIT) ? bbe_pkg::HEIGHT_LIMIT : int'(h_raw);
   endtask

   // random pixels, all white, or a checkerboard of black and white
   task automatic run_frame(int pattern, logic noisy);
      logic [23:0] pix;
      for (int k = 0; k < cur_w * cur_h; k++) begin
         if (noisy && $urandom_range(0, 15) == 0) send_item(bbe_pkg::REQ_DRAIN, 24'($urandom));
         unique case (pattern)
            PAT_WHITE:   pix = 24'hFFFFFF;
            PAT_CHECKER: pix = ((k % cur_w + k / cur_w) % 2) ? 24'hFFFFFF : 24'h000000;
            default:     pix = 24'($urandom);
         endcase
         send_item(bbe_pkg::REQ_PIXEL, pix);
      end
      if (noisy && $urandom_range(0, 3) == 0) send_item(bbe_pkg::REQ_PIXEL, 24'($urandom));
      for (int k = 0; k <= cur_w; k++) send_item(bbe_pkg::REQ_DRAIN, 24'($urandom));
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: corners, edges and interior with extreme values
      set_frame(11'd3, 13'd3);
      run_frame(PAT_WHITE, 1'b1);
      run_frame(PAT_CHECKER, 1'b0);
      set_frame(11'd1, 13'd1);
      run_frame(PAT_RANDOM, 1'b1);

      // zero register values count as one
      set_frame(11'd0, 13'd0);
      run_frame(PAT_RANDOM, 1'b1);

      set_frame(11'($urandom_range(1, 9)), 13'($urandom_range(1, 6)));
      while (items_sent < 1250) begin
         req_busy_mode = ($urandom_range(0, 3) != 0);
         rsp_busy_mode = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 2) == 0)
            set_frame(11'($urandom_range(1, 9)), 13'($urandom_range(1, 6)));
         run_frame(($urandom_range(0, 9) == 0) ? PAT_CHECKER : PAT_RANDOM,
                   ($urandom_range(0, 4) == 0));
      end

      req_tvalid <= 1'b0;
      while (blur_pending != 0) @(posedge clock);
      repeat (32) @(posedge clock);
      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #5ms;
      $display("Test completed with failures");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+design
design/bbe_pkg.sv
design/bbe_queue.sv
design/bbe_front.sv
design/bbe_back.sv
design/box_blur_3x3_edge_aware_unit.sv
verif/box_blur_3x3_edge_aware_unit_chk.sv
verif/box_blur_3x3_edge_aware_unit_tb.sv
